@@ hdl/gspa_pkg.sv @@
// gspa_pkg: shared types and constants of the growable slot pool allocator
// no dependencies; used by gspa_limits, growable_slot_pool_allocator and the testbench
`default_nettype none

package gspa_pkg;

  // field widths fixed by the transaction format
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // largest slot count a 7-bit register can ask for
  localparam int unsigned MAX_COUNT = 127;

  localparam logic [CNT_W-1:0] DEFAULT_SLOTS  = 7'd10;
  localparam logic [CNT_W-1:0] RST_INIT_SLOTS = 7'd10;
  localparam logic [CNT_W-1:0] RST_SOFT_LIMIT = 7'd10;
  localparam logic [CNT_W-1:0] RST_HARD_LIMIT = 7'd10;
  localparam logic [CNT_W-1:0] RST_GROW_STEP  = 7'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_EXISTING  = 2'd0,
    STAT_GROWN     = 2'd1,
    STAT_REFUSED   = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_SLOTS = 2'd0,
    REG_SOFT_LIMIT    = 2'd1,
    REG_HARD_LIMIT    = 2'd2,
    REG_GROW_STEP     = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_REL_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot_index;
    logic [1:0]        status;
    logic              soft_exceeded;
    logic [CNT_W-1:0]  pool_size;
    logic [CNT_W-1:0]  busy_count;
    logic [CNT_W-1:0]  live_soft_limit;
  } out_item_t;

  // raw configuration registers
  typedef struct packed {
    logic [CNT_W-1:0] initial_slots;
    logic [CNT_W-1:0] soft_limit;
    logic [CNT_W-1:0] hard_limit;
    logic [CNT_W-1:0] grow_step;
  } cfg_regs_t;

  // normalized limits loaded into the pool at initialization
  typedef struct packed {
    logic [CNT_W-1:0] init_slots;
    logic [CNT_W-1:0] soft_lvl;
    logic [CNT_W-1:0] hard;
    logic [CNT_W-1:0] step;
  } limits_t;

endpackage

`default_nettype wire

@@ hdl/gspa_limits.sv @@
// gspa_limits: normalizes the configuration registers into pool limits
// depends on gspa_pkg
`default_nettype none

module gspa_limits #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  var gspa_pkg::cfg_regs_t regs_i,
  output var gspa_pkg::limits_t   limits_o
);

  localparam int unsigned CAP_INT =
    (POOL_DEPTH < gspa_pkg::MAX_COUNT) ? POOL_DEPTH : gspa_pkg::MAX_COUNT;
  localparam logic [gspa_pkg::CNT_W-1:0] CAP = gspa_pkg::CNT_W'(CAP_INT);

  logic [gspa_pkg::CNT_W-1:0] init_raw;
  logic [gspa_pkg::CNT_W-1:0] init_clip;
  logic [gspa_pkg::CNT_W-1:0] soft_lvl;
  logic [gspa_pkg::CNT_W-1:0] hard_raw;

  always_comb begin
    init_raw  = (regs_i.initial_slots > 7'd1) ? regs_i.initial_slots
                                              : gspa_pkg::DEFAULT_SLOTS;
    init_clip = (init_raw > CAP) ? CAP : init_raw;
    soft_lvl  = (init_clip > regs_i.soft_limit) ? init_clip : regs_i.soft_limit;
    hard_raw  = (soft_lvl > regs_i.hard_limit) ? soft_lvl : regs_i.hard_limit;

    limits_o.init_slots = init_clip;
    limits_o.soft_lvl   = soft_lvl;
    limits_o.hard       = (hard_raw > CAP) ? CAP : hard_raw;
    limits_o.step       = (regs_i.grow_step == '0) ? 7'd1 : regs_i.grow_step;
  end

endmodule

`default_nettype wire

@@ hdl/growable_slot_pool_allocator.sv @@
// growable_slot_pool_allocator: round-robin slot pool with growth and limits
// depends on gspa_pkg and gspa_limits
// steps: query goes from idle to done, release checks the mark first, allocate
//   probes marks in the scan state, at most the pool size of them; one transaction
//   in flight (mark ram with one read and one write port, reads pipelined one per
//   cycle), the result register lets the next transaction in while a result waits
// reset and every config write start a clearing pass over all min(POOL_DEPTH,127)
//   mark ram addresses, during which no transaction is accepted
`default_nettype none

module growable_slot_pool_allocator #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  var logic                                   clk_i,
  input  var logic                                   rst_ni,
  // request channel
  input  var logic                                   in_valid_i,
  output var logic                                   in_ready_o,
  input  var gspa_pkg::in_item_t                     in_item_i,
  // result channel
  output var logic                                   out_valid_o,
  input  var logic                                   out_ready_i,
  output var gspa_pkg::out_item_t                    out_item_o,
  // configuration write port
  input  var logic                                   cfg_we_i,
  input  var logic [gspa_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  var logic [gspa_pkg::CNT_W-1:0]             cfg_data_i
);

  // slots beyond 127 can never be requested by a 7-bit register
  localparam int unsigned MEM_DEPTH =
    (POOL_DEPTH < gspa_pkg::MAX_COUNT) ? POOL_DEPTH : gspa_pkg::MAX_COUNT;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  localparam int unsigned CW = gspa_pkg::CNT_W;

  // ---------------------------------------------------------------------------
  // configuration registers and normalized limits
  // ---------------------------------------------------------------------------
  gspa_pkg::cfg_regs_t regs_q;
  gspa_pkg::limits_t   limits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.initial_slots <= gspa_pkg::RST_INIT_SLOTS;
      regs_q.soft_limit    <= gspa_pkg::RST_SOFT_LIMIT;
      regs_q.hard_limit    <= gspa_pkg::RST_HARD_LIMIT;
      regs_q.grow_step     <= gspa_pkg::RST_GROW_STEP;
    end else if (cfg_we_i) begin
      unique case (gspa_pkg::cfg_reg_e'(cfg_idx_i))
        gspa_pkg::REG_INITIAL_SLOTS: regs_q.initial_slots <= cfg_data_i;
        gspa_pkg::REG_SOFT_LIMIT:    regs_q.soft_limit    <= cfg_data_i;
        gspa_pkg::REG_HARD_LIMIT:    regs_q.hard_limit    <= cfg_data_i;
        gspa_pkg::REG_GROW_STEP:     regs_q.grow_step     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gspa_limits #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_limits (
    .regs_i   (regs_q),
    .limits_o (limits)
  );

  // ---------------------------------------------------------------------------
  // in-use mark ram: one bit per slot, synchronous read into rd_data_q with registered latency
  // ---------------------------------------------------------------------------
  logic          mark_mem [MEM_DEPTH];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_data_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mark_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mark_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // pool state
  // ---------------------------------------------------------------------------
  gspa_pkg::state_e   state_q, state_d;
  logic [CW-1:0]      present_q, present_d;   // slots present
  logic [CW:0]        soft_q, soft_d;         // live soft limit, may reach 128
  logic [CW-1:0]      hard_q, hard_d;
  logic [CW-1:0]      step_q, step_d;
  logic [CW-1:0]      busy_q, busy_d;         // marks set
  logic [CW-1:0]      ptr_q, ptr_d;           // round-robin start
  logic [CW-1:0]      chk_q, chk_d;           // slot whose mark is in rd_data_q
  logic [CW-1:0]      left_q, left_d;         // probes still to examine
  logic [CW-1:0]      rel_q, rel_d;
  logic [AW-1:0]      clr_q, clr_d;
  gspa_pkg::out_item_t res_q, res_d;          // finished result waiting for the output reg
  gspa_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic               load_out;

  logic               in_fire;
  logic [CW-1:0]      start_ptr;
  logic [CW-1:0]      scan_inc;
  logic [CW-1:0]      scan_next;
  logic [CW:0]        grow_sum;
  logic [CW-1:0]      grow_size;
  logic [CW-1:0]      grow_inc;
  logic [CW-1:0]      rel_ext;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    start_ptr = (ptr_q >= present_q) ? '0 : ptr_q;
    scan_inc  = chk_q + 7'd1;
    scan_next = (scan_inc >= present_q) ? '0 : scan_inc;
    grow_sum  = {1'b0, present_q} + {1'b0, step_q};
    grow_size = (grow_sum > {1'b0, hard_q}) ? hard_q : grow_sum[CW-1:0];
    grow_inc  = present_q + 7'd1;
    rel_ext   = {1'b0, in_item_i.release_slot};
  end

  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    soft_d    = soft_q;
    hard_d    = hard_q;
    step_d    = step_q;
    busy_d    = busy_q;
    ptr_d     = ptr_q;
    chk_d     = chk_q;
    left_d    = left_q;
    rel_d     = rel_q;
    clr_d     = clr_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = 1'b0;
    load_out  = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      // sweep the mark ram, reload the pool from the normalized limits
      gspa_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_q;
        wr_data   = 1'b0;
        clr_d     = clr_q + AW'(1);
        present_d = limits.init_slots;
        soft_d    = {1'b0, limits.soft_lvl};
        hard_d    = limits.hard;
        step_d    = limits.step;
        busy_d    = '0;
        ptr_d     = '0;
        if (clr_q == LAST_ADDR) begin
          state_d = gspa_pkg::ST_IDLE;
        end
      end

      gspa_pkg::ST_IDLE: begin
        in_ready_o = !cfg_we_i;
        if (in_fire) begin
          res_d.granted       = 1'b0;
          res_d.slot_index    = '0;
          res_d.status        = gspa_pkg::STAT_NOT_ALLOC;
          res_d.soft_exceeded = 1'b0;
          case (in_item_i.op)
            gspa_pkg::OP_ALLOC: begin
              // first probe goes out now, its mark arrives in the scan state
              rd_en   = 1'b1;
              rd_addr = start_ptr[AW-1:0];
              chk_d   = start_ptr;
              left_d  = present_q;
              state_d = gspa_pkg::ST_SCAN;
            end
            gspa_pkg::OP_RELEASE: begin
              rel_d = rel_ext;
              if (rel_ext < present_q) begin
                rd_en   = 1'b1;
                rd_addr = rel_ext[AW-1:0];
                state_d = gspa_pkg::ST_REL_CHK;
              end else begin
                // absent slot: nothing to clear
                state_d = gspa_pkg::ST_DONE;
              end
            end
            default: begin
              // query, and the unused code behaves as a query
              state_d = gspa_pkg::ST_DONE;
            end
          endcase
        end
      end

      // one mark examined per cycle while the next read is already issued
      gspa_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_next[AW-1:0];
        if (!rd_data_q) begin
          wr_en   = 1'b1;
          wr_addr = chk_q[AW-1:0];
          wr_data = 1'b1;
          busy_d  = busy_q + 7'd1;
          ptr_d   = scan_next;
          res_d.granted    = 1'b1;
          res_d.slot_index = chk_q[gspa_pkg::SLOT_W-1:0];
          res_d.status     = gspa_pkg::STAT_EXISTING;
          state_d = gspa_pkg::ST_DONE;
        end else if (left_q == 7'd1) begin
          // full circle without a free slot; scan_next is back at the start
          res_d.soft_exceeded = ({1'b0, present_q} > soft_q);
          if (present_q < hard_q) begin
            // grow; the first new slot was never marked since the last clear
            wr_en     = 1'b1;
            wr_addr   = present_q[AW-1:0];
            wr_data   = 1'b1;
            busy_d    = busy_q + 7'd1;
            present_d = grow_size;
            ptr_d     = (grow_inc >= grow_size) ? '0 : grow_inc;
            res_d.granted    = 1'b1;
            res_d.slot_index = present_q[gspa_pkg::SLOT_W-1:0];
            res_d.status     = gspa_pkg::STAT_GROWN;
          end else begin
            ptr_d  = scan_next;
            soft_d = {1'b0, hard_q} + 8'd1;
            res_d.granted    = 1'b0;
            res_d.slot_index = '0;
            res_d.status     = gspa_pkg::STAT_REFUSED;
          end
          state_d = gspa_pkg::ST_DONE;
        end else begin
          chk_d  = scan_next;
          left_d = left_q - 7'd1;
        end
      end

      // release: clear the mark only if it was set
      gspa_pkg::ST_REL_CHK: begin
        if (rd_data_q) begin
          wr_en   = 1'b1;
          wr_addr = rel_q[AW-1:0];
          wr_data = 1'b0;
          busy_d  = busy_q - 7'd1;
        end
        state_d = gspa_pkg::ST_DONE;
      end

      // hand the result to the output register once it is free
      gspa_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = gspa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = gspa_pkg::ST_CLEAR;
        clr_d   = '0;
      end
    endcase

    // pool figures reported as they stand after the transaction
    if (state_q != gspa_pkg::ST_DONE && state_d == gspa_pkg::ST_DONE) begin
      res_d.pool_size       = present_d;
      res_d.busy_count      = busy_d;
      res_d.live_soft_limit = soft_d[CW-1:0];
    end

    // any config write re-initializes the pool with a fresh clearing pass
    if (cfg_we_i) begin
      state_d = gspa_pkg::ST_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gspa_pkg::ST_CLEAR;
      clr_q       <= '0;
      present_q   <= gspa_pkg::RST_INIT_SLOTS;
      soft_q      <= {1'b0, gspa_pkg::RST_SOFT_LIMIT};
      hard_q      <= gspa_pkg::RST_HARD_LIMIT;
      step_q      <= gspa_pkg::RST_GROW_STEP;
      busy_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      present_q <= present_d;
      soft_q    <= soft_d;
      hard_q    <= hard_d;
      step_q    <= step_d;
      busy_q    <= busy_d;
      ptr_q     <= ptr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_q  <= chk_d;
    left_q <= left_d;
    rel_q  <= rel_d;
    res_q  <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_within_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q <= present_q)
    else $error("more marks set than slots present");

  a_pool_within_hard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q <= hard_q)
    else $error("pool grew past the hard limit");

  a_ptr_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < present_q)
    else $error("round-robin pointer outside the pool");

  a_scan_has_probes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gspa_pkg::ST_SCAN |-> left_q != '0)
    else $error("scan running with no probes left");

  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.granted |->
      out_item_o.status == gspa_pkg::STAT_EXISTING ||
      out_item_o.status == gspa_pkg::STAT_GROWN)
    else $error("grant reported with a non-grant status");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking regression for growable_slot_pool_allocator
// depends on gspa_pkg and the allocator rtl; directed table, then random phases

module testbench;

  import gspa_pkg::*;

  localparam int unsigned POOL_DEPTH = 64;
  // request transactions in the whole run, directed rows included
  localparam int unsigned TOTAL_ITEMS = 650;
  // from this many transactions on, both sides run without idling
  localparam int unsigned CALM_AFTER = 590;
  // op code three has no name in the package; the block treats it as a query
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_REQ,
    ROW_FIXED
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cfg_reg_e         reg_idx;
    logic [CNT_W-1:0] value;
    in_item_t         item;
    out_item_t        reply;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic      req_valid;
  logic      req_ready;
  in_item_t  req_item;
  logic      rsp_valid;
  logic      rsp_ready;
  out_item_t rsp_item;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CNT_W-1:0]     cfg_data;

  // shadow of the register file and the pool as the block should hold it
  logic [CNT_W-1:0] cfg_shadow [4];
  bit               mark_busy [POOL_DEPTH];
  int unsigned      next_probe;
  int unsigned      pool_now;
  int unsigned      warn_now;
  int unsigned      busy_now;
  int unsigned      hard_cap;
  int unsigned      grow_by;

  out_item_t   pending_replies [$];
  plan_row_t   plan [$];
  int unsigned sent;
  int unsigned fail_count;
  int unsigned gap_pct;
  int unsigned stall_pct;
  out_item_t   want;

  growable_slot_pool_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_item_i  (req_item),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_item_o (rsp_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // any register write starts the pool over from the normalized limits
  function automatic void reload_pool();
    int unsigned init_n, soft_n, hard_n;
    init_n = (cfg_shadow[REG_INITIAL_SLOTS] > 7'd1) ? cfg_shadow[REG_INITIAL_SLOTS]
                                                    : DEFAULT_SLOTS;
    if (init_n > POOL_DEPTH) init_n = POOL_DEPTH;
    // soft limit is raised to the initial count but never clipped
    soft_n = (init_n > cfg_shadow[REG_SOFT_LIMIT]) ? init_n : cfg_shadow[REG_SOFT_LIMIT];
    hard_n = (soft_n > cfg_shadow[REG_HARD_LIMIT]) ? soft_n : cfg_shadow[REG_HARD_LIMIT];
    if (hard_n > POOL_DEPTH) hard_n = POOL_DEPTH;
    for (int i = 0; i < POOL_DEPTH; i++) mark_busy[i] = 1'b0;
    next_probe = 0;
    pool_now   = init_n;
    warn_now   = soft_n;
    busy_now   = 0;
    hard_cap   = hard_n;
    grow_by    = (cfg_shadow[REG_GROW_STEP] == '0) ? 1 : cfg_shadow[REG_GROW_STEP];
  endfunction

  // advances the shadow pool by one request and returns the reply it should give
  function automatic out_item_t predict_pool_reply(in_item_t it);
    out_item_t   r;
    int unsigned p, lim;
    bit          found;
    r = '0;
    r.status = STAT_NOT_ALLOC;
    if (it.op == OP_ALLOC) begin
      found = 1'b0;
      // a stale pointer past the pool end restarts the scan at slot zero
      p = (next_probe >= pool_now) ? 0 : next_probe;
      for (int unsigned i = 0; i < pool_now && !found; i++) begin
        if (!mark_busy[p]) begin
          mark_busy[p] = 1'b1;
          busy_now++;
          found = 1'b1;
          r.slot_index = p[SLOT_W-1:0];
        end
        p++;
        if (p >= pool_now) p = 0;
      end
      if (found) begin
        next_probe = p;
        r.granted  = 1'b1;
        r.status   = STAT_EXISTING;
      end else begin
        r.soft_exceeded = (pool_now > warn_now);
        if (pool_now < hard_cap) begin
          // grow, clipped at the hard limit, and hand out the first new slot
          lim = pool_now + grow_by;
          if (lim > hard_cap) lim = hard_cap;
          r.slot_index = pool_now[SLOT_W-1:0];
          if (!mark_busy[pool_now]) begin
            mark_busy[pool_now] = 1'b1;
            busy_now++;
          end
          p = pool_now + 1;
          pool_now = lim;
          next_probe = (p >= pool_now) ? 0 : p;
          r.granted = 1'b1;
          r.status  = STAT_GROWN;
        end else begin
          // exhausted at the hard limit: refuse and lift the warning level
          next_probe = p;
          warn_now   = hard_cap + 1;
          r.status   = STAT_REFUSED;
        end
      end
    end else if (it.op == OP_RELEASE) begin
      // absent slots and free slots are left alone
      if (it.release_slot < pool_now && mark_busy[it.release_slot]) begin
        mark_busy[it.release_slot] = 1'b0;
        busy_now--;
      end
    end
    r.pool_size       = pool_now[CNT_W-1:0];
    r.busy_count      = busy_now[CNT_W-1:0];
    r.live_soft_limit = warn_now[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] pick_reg_value(cfg_reg_e idx);
    int unsigned k;
    k = $urandom_range(0, 9);
    case (idx)
      REG_INITIAL_SLOTS: begin
        case (k)
          0:       return 7'd0;
          1:       return 7'd1;
          2:       return 7'd64;
          3:       return 7'd127;
          4:       return 7'($urandom_range(0, 127));
          default: return 7'($urandom_range(2, 12));
        endcase
      end
      REG_SOFT_LIMIT: begin
        case (k)
          0:       return 7'd0;
          1:       return 7'd64;
          2:       return 7'd127;
          default: return 7'($urandom_range(0, 16));
        endcase
      end
      REG_HARD_LIMIT: begin
        case (k)
          0:       return 7'd0;
          1:       return 7'd64;
          2:       return 7'd127;
          default: return 7'($urandom_range(0, 24));
        endcase
      end
      default: begin
        case (k)
          0:       return 7'd0;
          1:       return 7'd1;
          2:       return 7'd64;
          3:       return 7'd127;
          default: return 7'($urandom_range(1, 6));
        endcase
      end
    endcase
  endfunction

  function automatic void plan_cfg(cfg_reg_e idx, logic [CNT_W-1:0] value);
    plan_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, value: value, item: '0, reply: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
    plan_row_t row;
    row = '{kind: ROW_REQ, reg_idx: REG_INITIAL_SLOTS, value: '0, item: '0, reply: '0};
    row.item.op = op;
    row.item.release_slot = slot;
    plan.push_back(row);
  endfunction

  // a row whose reply is written out by hand
  function automatic void plan_fixed(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                     logic g, logic [SLOT_W-1:0] idx, status_e st,
                                     logic warn, int unsigned pool, int unsigned busy,
                                     int unsigned live);
    plan_row_t row;
    row = '{kind: ROW_FIXED, reg_idx: REG_INITIAL_SLOTS, value: '0, item: '0, reply: '0};
    row.item.op                = op;
    row.item.release_slot      = slot;
    row.reply.granted          = g;
    row.reply.slot_index       = idx;
    row.reply.status           = st;
    row.reply.soft_exceeded    = warn;
    row.reply.pool_size        = pool[CNT_W-1:0];
    row.reply.busy_count       = busy[CNT_W-1:0];
    row.reply.live_soft_limit  = live[CNT_W-1:0];
    plan.push_back(row);
  endfunction

  // offer one request transaction; valid stays up afterwards unless a gap follows
  task automatic send_req(input in_item_t it, input bit fixed, input out_item_t fixed_reply);
    out_item_t guess;
    if ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    do @(posedge clk); while (!req_ready);
    guess = predict_pool_reply(it);
    pending_replies.push_back(fixed ? fixed_reply : guess);
    sent++;
  endtask

  // drop valid and wait until every reply is back
  task automatic settle_block();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // single register write; the block then runs its clearing pass
  task automatic write_reg(input cfg_reg_e idx, input logic [CNT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_shadow[idx] = value;
    reload_pool();
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // result side: random stall bursts while stall_pct is nonzero
  initial begin
    rsp_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp_ready <= 1'b1;
      end
    end
  end

  // every accepted result transaction is matched against the oldest prediction
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: g=%0d slot=%0d st=%0d warn=%0d pool=%0d busy=%0d live=%0d",
                   rsp_item.granted, rsp_item.slot_index, rsp_item.status,
                   rsp_item.soft_exceeded, rsp_item.pool_size, rsp_item.busy_count,
                   rsp_item.live_soft_limit);
        end
      end else begin
        want = pending_replies.pop_front();
        if (rsp_item.granted !== want.granted || rsp_item.slot_index !== want.slot_index ||
            rsp_item.status !== want.status || rsp_item.soft_exceeded !== want.soft_exceeded ||
            rsp_item.pool_size !== want.pool_size || rsp_item.busy_count !== want.busy_count ||
            rsp_item.live_soft_limit !== want.live_soft_limit) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t: exp g=%0d slot=%0d st=%0d warn=%0d pool=%0d busy=%0d live=%0d",
                     $realtime, want.granted, want.slot_index, want.status,
                     want.soft_exceeded, want.pool_size, want.busy_count,
                     want.live_soft_limit);
            $display("              got g=%0d slot=%0d st=%0d warn=%0d pool=%0d busy=%0d live=%0d",
                     rsp_item.granted, rsp_item.slot_index, rsp_item.status,
                     rsp_item.soft_exceeded, rsp_item.pool_size, rsp_item.busy_count,
                     rsp_item.live_soft_limit);
          end
        end
      end
    end
  end

  initial begin
    in_item_t    it;
    int unsigned n_items, pick;
    int          busy_list [$];

    req_valid <= 1'b0;
    req_item  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    sent       = 0;
    fail_count = 0;
    gap_pct    = 25;
    stall_pct  = 25;
    cfg_shadow[REG_INITIAL_SLOTS] = RST_INIT_SLOTS;
    cfg_shadow[REG_SOFT_LIMIT]    = RST_SOFT_LIMIT;
    cfg_shadow[REG_HARD_LIMIT]    = RST_HARD_LIMIT;
    cfg_shadow[REG_GROW_STEP]     = RST_GROW_STEP;
    reload_pool();

    // reset state: ten slots, limits ten, step one
    plan_fixed(OP_QUERY,   6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 0, 10);
    plan_fixed(OP_UNUSED,  6'd63, 1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 0, 10);
    plan_fixed(OP_ALLOC,   6'd0,  1'b1, 6'd0, STAT_EXISTING,  1'b0, 10, 1, 10);
    plan_fixed(OP_ALLOC,   6'd63, 1'b1, 6'd1, STAT_EXISTING,  1'b0, 10, 2, 10);
    plan_fixed(OP_RELEASE, 6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 1, 10);
    // releasing a slot that is already free
    plan_fixed(OP_RELEASE, 6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 1, 10);
    // releasing a slot beyond the pool
    plan_fixed(OP_RELEASE, 6'd63, 1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 1, 10);
    plan_req(OP_ALLOC, 6'd0);
    // tiny pool: two slots, hard limit three, step zero means one
    plan_cfg(REG_INITIAL_SLOTS, 7'd2);
    plan_cfg(REG_SOFT_LIMIT,    7'd0);
    plan_cfg(REG_HARD_LIMIT,    7'd3);
    plan_cfg(REG_GROW_STEP,     7'd0);
    plan_fixed(OP_QUERY,   6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 2, 0, 2);
    plan_req(OP_ALLOC, 6'd0);
    plan_req(OP_ALLOC, 6'd0);
    plan_fixed(OP_ALLOC,   6'd0,  1'b1, 6'd2, STAT_GROWN,     1'b0, 3, 3, 2);
    plan_fixed(OP_ALLOC,   6'd0,  1'b0, 6'd0, STAT_REFUSED,   1'b1, 3, 3, 4);
    plan_fixed(OP_ALLOC,   6'd0,  1'b0, 6'd0, STAT_REFUSED,   1'b0, 3, 3, 4);
    plan_req(OP_RELEASE, 6'd1);
    plan_req(OP_ALLOC,   6'd0);
    plan_req(OP_RELEASE, 6'd2);
    plan_req(OP_RELEASE, 6'd0);
    plan_req(OP_ALLOC,   6'd0);
    // every register at its top: pool clipped to full depth, soft limit kept
    plan_cfg(REG_INITIAL_SLOTS, 7'd127);
    plan_cfg(REG_SOFT_LIMIT,    7'd127);
    plan_cfg(REG_HARD_LIMIT,    7'd127);
    plan_cfg(REG_GROW_STEP,     7'd127);
    plan_fixed(OP_QUERY,   6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 64, 0, 127);
    plan_req(OP_ALLOC, 6'd0);
    plan_fixed(OP_RELEASE, 6'd63, 1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 64, 1, 127);
    // big step from two slots jumps straight to the hard limit
    plan_cfg(REG_INITIAL_SLOTS, 7'd2);
    plan_cfg(REG_SOFT_LIMIT,    7'd0);
    plan_cfg(REG_HARD_LIMIT,    7'd64);
    plan_req(OP_ALLOC, 6'd0);
    plan_req(OP_ALLOC, 6'd0);
    plan_fixed(OP_ALLOC,   6'd0,  1'b1, 6'd2, STAT_GROWN,     1'b0, 64, 3, 2);
    // initial count of one falls back to ten
    plan_cfg(REG_INITIAL_SLOTS, 7'd1);
    plan_fixed(OP_QUERY,   6'd0,  1'b0, 6'd0, STAT_NOT_ALLOC, 1'b0, 10, 0, 10);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_CFG: begin
          settle_block();
          write_reg(plan[r].reg_idx, plan[r].value);
        end
        ROW_REQ:   send_req(plan[r].item, 1'b0, '0);
        default:   send_req(plan[r].item, 1'b1, plan[r].reply);
      endcase
    end

    // random phases: fresh limits, then a run of mostly alloc and release
    while (sent < TOTAL_ITEMS) begin
      settle_block();
      for (int r = 0; r < 4; r++) write_reg(cfg_reg_e'(r), pick_reg_value(cfg_reg_e'(r)));
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 40;
      endcase
      n_items = $urandom_range(30, 80);
      if (n_items > TOTAL_ITEMS - sent) n_items = TOTAL_ITEMS - sent;
      for (int k = 0; k < n_items; k++) begin
        if (sent >= CALM_AFTER) begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        it.release_slot = SLOT_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
          it.op = OP_ALLOC;
        end else if (pick < 83) begin
          it.op = OP_RELEASE;
          // usually free a slot that is really held
          if ($urandom_range(0, 3) != 0) begin
            busy_list.delete();
            for (int s = 0; s < pool_now; s++) begin
              if (mark_busy[s]) busy_list.push_back(s);
            end
            if (busy_list.size() != 0) begin
              it.release_slot =
                SLOT_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            end
          end
        end else if (pick < 95) begin
          it.op = OP_QUERY;
        end else begin
          it.op = OP_UNUSED;
        end
        send_req(it, 1'b0, '0);
      end
    end

    settle_block();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
